FILE: sv/gfwm_pkg.sv
// ----------------------------------------------------------------------------
// gfwm_pkg
// shared constants and types for the glyph fallback width measure block
// ----------------------------------------------------------------------------
package gfwm_pkg;

    localparam int GLYPH_COUNT = 256;
    localparam int CODE_BITS   = $clog2(GLYPH_COUNT);
    localparam int ADV_BITS    = 8;
    localparam int SUM_BITS    = 16;
    localparam int FONT_BITS   = 16;
    localparam int WIDTH_BITS  = 16;
    localparam int KIND_BITS   = 3;
    localparam int INDEX_BITS  = 2;

    localparam int GROUP_SIZE  = 16;
    localparam int GROUP_COUNT = GLYPH_COUNT / GROUP_SIZE;
    localparam int GIDX_BITS   = $clog2(GROUP_SIZE);
    localparam int GSEL_BITS   = $clog2(GROUP_COUNT);

    localparam logic [CODE_BITS-1:0] SPACE_CODE = CODE_BITS'(32);
    localparam logic [CODE_BITS-1:0] CASE_BIT   = CODE_BITS'(32);
    localparam logic [CODE_BITS-1:0] UPPER_LO   = CODE_BITS'(8'h41);
    localparam logic [CODE_BITS-1:0] UPPER_HI   = CODE_BITS'(8'h5a);
    localparam logic [CODE_BITS-1:0] LOWER_LO   = CODE_BITS'(8'h61);
    localparam logic [CODE_BITS-1:0] LOWER_HI   = CODE_BITS'(8'h7a);

    localparam logic MODE_LOAD    = 1'b0;
    localparam logic MODE_MEASURE = 1'b1;

    localparam logic [INDEX_BITS-1:0] REG_ASCENT  = INDEX_BITS'(0);
    localparam logic [INDEX_BITS-1:0] REG_DESCENT = INDEX_BITS'(1);

    localparam logic [KIND_BITS-1:0] KIND_EXACT   = KIND_BITS'(0);
    localparam logic [KIND_BITS-1:0] KIND_SWAPPED = KIND_BITS'(1);
    localparam logic [KIND_BITS-1:0] KIND_SPACE   = KIND_BITS'(2);
    localparam logic [KIND_BITS-1:0] KIND_FIRST   = KIND_BITS'(3);
    localparam logic [KIND_BITS-1:0] KIND_EMPTY   = KIND_BITS'(4);

    typedef struct packed {
        logic                 found;
        logic [CODE_BITS-1:0] code;
        logic [KIND_BITS-1:0] kind;
    } resolve_t;

endpackage

FILE: sv/glyph_fallback_width_measure.sv
// ----------------------------------------------------------------------------
// glyph_fallback_width_measure
// glyph table with fallback lookup and a saturating running string width
// ----------------------------------------------------------------------------
// usage:
//   input channel (in_valid / in_stall) carries load and measure items.
//   a load item writes one glyph entry in its transfer cycle; it gives no
//   result and the next item may follow in the next cycle.
//   a measure item runs in steps: the transfer captures the code and
//   the per-group present summary, ST_SCAN resolves the entry and reads
//   the width memory, and ST_ACC adds the advance into the running sum
//   and loads the output register. in_stall stays high from the transfer
//   until that last step is done, so no new item is taken before the
//   measure is through.
//   the output register holds a result until out_stall drops; the block
//   then waits in its last step with in_stall high.
//   cfg_we writes ascent or descent; do it only while the block is idle.
//   reset clears all present bits, the sum, the clipped flag and both font
//   registers; the width memory is not cleared.
// ----------------------------------------------------------------------------
module glyph_fallback_width_measure (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  cfg_we,
    input  logic [gfwm_pkg::INDEX_BITS-1:0]       cfg_index,
    input  logic [gfwm_pkg::FONT_BITS-1:0]        cfg_data,
    input  logic                                  in_valid,
    output logic                                  in_stall,
    input  logic                                  mode,
    input  logic [gfwm_pkg::CODE_BITS-1:0]        char_code,
    input  logic                                  present,
    input  logic signed [gfwm_pkg::ADV_BITS-1:0]  advance,
    input  logic                                  last,
    output logic                                  out_valid,
    input  logic                                  out_stall,
    output logic [gfwm_pkg::CODE_BITS-1:0]        glyph_code,
    output logic signed [gfwm_pkg::ADV_BITS-1:0]  glyph_advance,
    output logic [gfwm_pkg::KIND_BITS-1:0]        resolve_kind,
    output logic signed [gfwm_pkg::WIDTH_BITS-1:0] string_width,
    output logic                                  width_clipped,
    output logic signed [gfwm_pkg::FONT_BITS-1:0] ascent,
    output logic signed [gfwm_pkg::FONT_BITS-1:0] descent,
    output logic                                  string_end
);
    import gfwm_pkg::*;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_SCAN = 2'd1;
    localparam logic [1:0] ST_ACC  = 2'd2;

    localparam logic signed [SUM_BITS:0] SUM_MAX = {2'b00, {(SUM_BITS-1){1'b1}}};
    localparam logic signed [SUM_BITS:0] SUM_MIN = {2'b11, {(SUM_BITS-1){1'b0}}};

    logic [1:0]                 state_reg;
    logic [1:0]                 state_next;
    logic [GLYPH_COUNT-1:0]     present_reg;
    logic [ADV_BITS-1:0]        width_mem [GLYPH_COUNT];
    logic [ADV_BITS-1:0]        rd_data_reg;
    logic                       last_reg;
    resolve_t                   resolved;
    resolve_t                   res_reg;
    logic signed [SUM_BITS-1:0] width_sum_reg;
    logic signed [SUM_BITS-1:0] width_sum_next;
    logic                       sum_clipped_reg;
    logic                       sum_clipped_next;
    logic signed [FONT_BITS-1:0] ascent_reg;
    logic signed [FONT_BITS-1:0] descent_reg;

    logic                       in_xfer;
    logic                       out_xfer;
    logic                       load_item;
    logic                       measure_item;
    logic                       out_load;
    logic signed [ADV_BITS-1:0] used_adv;
    logic signed [SUM_BITS:0]   sum_wide;
    logic signed [SUM_BITS-1:0] sum_sat;
    logic                       sat_hit;

    logic                       out_valid_reg;
    logic [CODE_BITS-1:0]       glyph_code_reg;
    logic signed [ADV_BITS-1:0] glyph_advance_reg;
    logic [KIND_BITS-1:0]       resolve_kind_reg;
    logic signed [WIDTH_BITS-1:0] string_width_reg;
    logic                       width_clipped_reg;
    logic signed [FONT_BITS-1:0] ascent_out_reg;
    logic signed [FONT_BITS-1:0] descent_out_reg;
    logic                       string_end_reg;

    assign in_stall     = (state_reg != ST_IDLE);
    assign in_xfer      = in_valid && !in_stall;
    assign out_xfer     = out_valid_reg && !out_stall;
    assign load_item    = in_xfer && (mode == MODE_LOAD);
    assign measure_item = in_xfer && (mode == MODE_MEASURE);
    assign out_load     = (state_reg == ST_ACC) && (!out_valid_reg || !out_stall);

    gfwm_resolve u_resolve (
        .clk          (clk),
        .rst_n        (rst_n),
        .capture      (measure_item),
        .code         (char_code),
        .present_bits (present_reg),
        .resolved     (resolved)
    );

    // config registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ascent_reg  <= '0;
            descent_reg <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_ASCENT:  ascent_reg  <= cfg_data;
                REG_DESCENT: descent_reg <= cfg_data;
                default:     ;
            endcase
        end
    end

    // present bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            present_reg <= '0;
        end
        else if (load_item)
        begin
            present_reg[char_code] <= present;
        end
    end

    // width memory, registered read
    always_ff @(posedge clk)
    begin
        if (load_item)
        begin
            width_mem[char_code] <= advance;
        end
        if (state_reg == ST_SCAN)
        begin
            rd_data_reg <= width_mem[resolved.code];
        end
    end

    always_ff @(posedge clk)
    begin
        if (measure_item)
        begin
            last_reg <= last;
        end
        if (state_reg == ST_SCAN)
        begin
            res_reg <= resolved;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (measure_item)
                begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                state_next = ST_ACC;
            end
            ST_ACC:
            begin
                if (out_load)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // saturating accumulate
    always_comb
    begin
        used_adv = res_reg.found ? $signed(rd_data_reg) : '0;
        sum_wide = (SUM_BITS+1)'(width_sum_reg) + (SUM_BITS+1)'(used_adv);
        sat_hit  = 1'b0;
        sum_sat  = sum_wide[SUM_BITS-1:0];
        if (sum_wide > SUM_MAX)
        begin
            sum_sat = SUM_MAX[SUM_BITS-1:0];
            sat_hit = 1'b1;
        end
        else if (sum_wide < SUM_MIN)
        begin
            sum_sat = SUM_MIN[SUM_BITS-1:0];
            sat_hit = 1'b1;
        end
        if (last_reg)
        begin
            width_sum_next   = '0;
            sum_clipped_next = 1'b0;
        end
        else
        begin
            width_sum_next   = sum_sat;
            sum_clipped_next = sum_clipped_reg || sat_hit;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            width_sum_reg   <= '0;
            sum_clipped_reg <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (out_load)
            begin
                width_sum_reg   <= width_sum_next;
                sum_clipped_reg <= sum_clipped_next;
                out_valid_reg   <= 1'b1;
            end
            else if (out_xfer)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // output register
    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            glyph_code_reg    <= res_reg.code;
            glyph_advance_reg <= used_adv;
            resolve_kind_reg  <= res_reg.kind;
            string_width_reg  <= WIDTH_BITS'(sum_sat);
            width_clipped_reg <= sum_clipped_reg || sat_hit;
            ascent_out_reg    <= ascent_reg;
            descent_out_reg   <= descent_reg;
            string_end_reg    <= last_reg;
        end
    end

    assign out_valid     = out_valid_reg;
    assign glyph_code    = glyph_code_reg;
    assign glyph_advance = glyph_advance_reg;
    assign resolve_kind  = resolve_kind_reg;
    assign string_width  = string_width_reg;
    assign width_clipped = width_clipped_reg;
    assign ascent        = ascent_out_reg;
    assign descent       = descent_out_reg;
    assign string_end    = string_end_reg;

    a_measure_enters_scan: assert property (@(posedge clk) disable iff (!rst_n)
        measure_item |=> (state_reg == ST_SCAN))
        else $error("measure transfer did not start resolve");

    a_load_stays_idle: assert property (@(posedge clk) disable iff (!rst_n)
        load_item |=> (state_reg == ST_IDLE))
        else $error("load transfer left idle");

    a_empty_gives_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (resolve_kind == KIND_EMPTY)) |->
        ((glyph_code == '0) && (glyph_advance == '0)))
        else $error("empty font result carries a glyph");

    a_end_clears_sum: assert property (@(posedge clk) disable iff (!rst_n)
        (out_load && last_reg) |=> ((width_sum_reg == '0) && !sum_clipped_reg))
        else $error("sum not cleared after string end");

    a_load_waits_output: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_stall) |-> !out_load)
        else $error("output register overwritten while stalled");

endmodule

FILE: sv/gfwm_resolve.sv
// ----------------------------------------------------------------------------
// gfwm_resolve
// picks the table entry for a measured code: exact, case swapped, space,
// lowest present or empty; present bits are reduced per group at capture
// ----------------------------------------------------------------------------
module gfwm_resolve (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            capture,
    input  logic [gfwm_pkg::CODE_BITS-1:0]  code,
    input  logic [gfwm_pkg::GLYPH_COUNT-1:0] present_bits,
    output gfwm_pkg::resolve_t              resolved
);
    import gfwm_pkg::*;

    logic [CODE_BITS-1:0]   code_reg;
    logic                   exact_reg;
    logic                   swap_reg;
    logic                   space_reg;
    logic [GROUP_COUNT-1:0] group_any_reg;
    logic [GIDX_BITS-1:0]   group_idx_reg [GROUP_COUNT];

    logic                   exact_next;
    logic                   swap_next;
    logic                   space_next;
    logic                   is_letter;
    logic [CODE_BITS-1:0]   swapped_code;
    logic [GROUP_COUNT-1:0] group_any_next;
    logic [GIDX_BITS-1:0]   group_idx_next [GROUP_COUNT];
    logic [GSEL_BITS-1:0]   group_sel;
    logic                   any_present;
    logic [CODE_BITS-1:0]   first_code;

    assign swapped_code = code ^ CASE_BIT;
    assign is_letter    = ((code >= UPPER_LO) && (code <= UPPER_HI))
                       || ((code >= LOWER_LO) && (code <= LOWER_HI));
    assign exact_next   = present_bits[code];
    assign swap_next    = is_letter && present_bits[swapped_code];
    assign space_next   = present_bits[SPACE_CODE];

    // per-group lowest set bit
    always_comb
    begin
        for (int g = 0; g < GROUP_COUNT; g++)
        begin
            group_any_next[g] = |present_bits[g*GROUP_SIZE +: GROUP_SIZE];
            group_idx_next[g] = '0;
            for (int b = GROUP_SIZE - 1; b >= 0; b--)
            begin
                if (present_bits[g*GROUP_SIZE + b])
                begin
                    group_idx_next[g] = GIDX_BITS'(b);
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            code_reg      <= '0;
            exact_reg     <= 1'b0;
            swap_reg      <= 1'b0;
            space_reg     <= 1'b0;
            group_any_reg <= '0;
        end
        else if (capture)
        begin
            code_reg      <= code;
            exact_reg     <= exact_next;
            swap_reg      <= swap_next;
            space_reg     <= space_next;
            group_any_reg <= group_any_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (capture)
        begin
            for (int g = 0; g < GROUP_COUNT; g++)
            begin
                group_idx_reg[g] <= group_idx_next[g];
            end
        end
    end

    // lowest non-empty group
    always_comb
    begin
        group_sel = '0;
        for (int g = GROUP_COUNT - 1; g >= 0; g--)
        begin
            if (group_any_reg[g])
            begin
                group_sel = GSEL_BITS'(g);
            end
        end
    end

    assign any_present = |group_any_reg;
    assign first_code  = {group_sel, group_idx_reg[group_sel]};

    always_comb
    begin
        resolved.found = 1'b1;
        resolved.code  = code_reg;
        resolved.kind  = KIND_EXACT;
        if (exact_reg)
        begin
            resolved.code = code_reg;
            resolved.kind = KIND_EXACT;
        end
        else if (swap_reg)
        begin
            resolved.code = code_reg ^ CASE_BIT;
            resolved.kind = KIND_SWAPPED;
        end
        else if (space_reg)
        begin
            resolved.code = SPACE_CODE;
            resolved.kind = KIND_SPACE;
        end
        else if (any_present)
        begin
            resolved.code = first_code;
            resolved.kind = KIND_FIRST;
        end
        else
        begin
            resolved.found = 1'b0;
            resolved.code  = '0;
            resolved.kind  = KIND_EMPTY;
        end
    end

endmodule
